// File: rtl/core/ir_thermometer_frame_receiver_macros.svh
// Assertion macros used by the frame receiver checker.
`ifndef IR_THERMOMETER_FRAME_RECEIVER_MACROS_SVH
`define IR_THERMOMETER_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IRTFR_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("irtfr same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IRTFR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("irtfr next-cycle check failed");

`endif

// File: rtl/core/irtfr_pkg.sv
// Types, constants and register codes of the IR thermometer frame receiver.
`timescale 1ns / 1ps

package irtfr_pkg;

  // Configuration address map
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_ID      = 3'd0,
    REG_AMBIENT_ID     = 3'd1,
    REG_END_MARK       = 3'd2,
    REG_TIMEOUT_TICKS  = 3'd3,
    REG_MAX_FRAMES     = 3'd4,
    REG_TARGET_OFFSET  = 3'd5,
    REG_AMBIENT_OFFSET = 3'd6
  } reg_idx_t;

  // Register reset values
  localparam logic [7:0]         RST_TARGET_ID      = 8'h4C;
  localparam logic [7:0]         RST_AMBIENT_ID     = 8'h66;
  localparam logic [7:0]         RST_END_MARK       = 8'h0D;
  localparam logic [21:0]        RST_TIMEOUT_TICKS  = 22'd4000000;
  localparam logic [1:0]         RST_MAX_FRAMES     = 2'd3;
  localparam logic signed [10:0] RST_TARGET_OFFSET  = 11'sd100;
  localparam logic signed [10:0] RST_AMBIENT_OFFSET = -11'sd100;

  // Input word codes
  localparam logic OP_START     = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;
  localparam logic KIND_TARGET  = 1'b0;
  localparam logic KIND_AMBIENT = 1'b1;

  // Frame geometry
  localparam int FRAME_BYTES = 5;
  localparam int FRAME_BITS  = 40;

  // Conversion constants: deg = trunc((raw*25 - 109260) / 400)
  localparam logic signed [22:0] RAW_BIAS  = 23'sd109260;
  localparam logic signed [19:0] DEG_SCALE = 20'sd100;
  // floor(m/25) = (m * RECIP_25) >> RECIP_SHIFT for m below 2^17
  localparam int RECIP_25    = 167773;
  // floor(x/10) = (x * RECIP_10) >> RECIP_SHIFT for x below 2^19
  localparam int RECIP_10    = 419431;
  localparam int RECIP_SHIFT = 22;
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Conversion pipeline length, output register included
  localparam int BACK_STAGES = 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]         target_id;
    logic [7:0]         ambient_id;
    logic [7:0]         end_mark;
    logic [21:0]        timeout_ticks;
    logic [1:0]         max_frames;
    logic signed [10:0] target_offset;
    logic signed [10:0] ambient_offset;
  } cfg_t;

  typedef struct packed {
    logic ack;
    logic busy;
    logic done;
    logic valid;
    logic kind;
  } flags_t;

  typedef struct packed {
    flags_t             flags;
    logic               live;
    logic [15:0]        raw;
    logic signed [10:0] offset;
  } stub_t;

endpackage

// File: rtl/core/irtfr_if.sv
// Valid/ready channel interfaces for sample words and result words.
`timescale 1ns / 1ps

interface irtfr_item_if;
  logic valid;
  logic ready;
  logic opcode;
  logic kind;
  logic clock_level;
  logic data_level;

  modport source (output valid, output opcode, output kind, output clock_level,
                  output data_level, input ready);
  modport sink   (input valid, input opcode, input kind, input clock_level,
                  input data_level, output ready);
endinterface

interface irtfr_result_if;
  logic               valid;
  logic               ready;
  logic               ack_level;
  logic               busy_res;
  logic               done_res;
  logic               valid_res;
  logic               reading_kind;
  logic signed [19:0] temperature_x100;
  logic               negative;
  logic [5:0]         digit_thousands;
  logic [5:0]         digit_hundreds;
  logic [5:0]         digit_tens;
  logic [5:0]         digit_units;

  modport source (output valid, output ack_level, output busy_res, output done_res,
                  output valid_res, output reading_kind, output temperature_x100,
                  output negative, output digit_thousands, output digit_hundreds,
                  output digit_tens, output digit_units, input ready);
  modport sink   (input valid, input ack_level, input busy_res, input done_res,
                  input valid_res, input reading_kind, input temperature_x100,
                  input negative, input digit_thousands, input digit_hundreds,
                  input digit_tens, input digit_units, output ready);
endinterface

// File: rtl/core/irtfr_regs.sv
// APB-style configuration register file of the frame receiver.
`timescale 1ns / 1ps

module irtfr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [irtfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output irtfr_pkg::cfg_t             cfg
);

  logic                             wr_en;
  logic [irtfr_pkg::REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[irtfr_pkg::ADDR_W-1:2];

  // Write the addressed register in the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_id      <= irtfr_pkg::RST_TARGET_ID;
      cfg.ambient_id     <= irtfr_pkg::RST_AMBIENT_ID;
      cfg.end_mark       <= irtfr_pkg::RST_END_MARK;
      cfg.timeout_ticks  <= irtfr_pkg::RST_TIMEOUT_TICKS;
      cfg.max_frames     <= irtfr_pkg::RST_MAX_FRAMES;
      cfg.target_offset  <= irtfr_pkg::RST_TARGET_OFFSET;
      cfg.ambient_offset <= irtfr_pkg::RST_AMBIENT_OFFSET;
    end else if (wr_en) begin
      case (idx)
        irtfr_pkg::REG_TARGET_ID:      cfg.target_id      <= pwdata[7:0];
        irtfr_pkg::REG_AMBIENT_ID:     cfg.ambient_id     <= pwdata[7:0];
        irtfr_pkg::REG_END_MARK:       cfg.end_mark       <= pwdata[7:0];
        irtfr_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[21:0];
        irtfr_pkg::REG_MAX_FRAMES:     cfg.max_frames     <= pwdata[1:0];
        irtfr_pkg::REG_TARGET_OFFSET:  cfg.target_offset  <= pwdata[10:0];
        irtfr_pkg::REG_AMBIENT_OFFSET: cfg.ambient_offset <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero extended
  always_comb begin
    case (idx)
      irtfr_pkg::REG_TARGET_ID:      prdata = {24'b0, cfg.target_id};
      irtfr_pkg::REG_AMBIENT_ID:     prdata = {24'b0, cfg.ambient_id};
      irtfr_pkg::REG_END_MARK:       prdata = {24'b0, cfg.end_mark};
      irtfr_pkg::REG_TIMEOUT_TICKS:  prdata = {10'b0, cfg.timeout_ticks};
      irtfr_pkg::REG_MAX_FRAMES:     prdata = {30'b0, cfg.max_frames};
      irtfr_pkg::REG_TARGET_OFFSET:  prdata = {21'b0, cfg.target_offset};
      irtfr_pkg::REG_AMBIENT_OFFSET: prdata = {21'b0, cfg.ambient_offset};
      default:                       prdata = 32'b0;
    endcase
  end

endmodule

// File: rtl/core/irtfr_front.sv
// Front end: takes sample words, tracks bit timing and assembles frames.
`timescale 1ns / 1ps

module irtfr_front (
  input  logic              clk,
  input  logic              rst,
  input  irtfr_pkg::cfg_t   cfg,
  irtfr_item_if.sink        items,
  input  logic              q_full,
  output logic              q_push,
  output irtfr_pkg::stub_t  q_data
);

  irtfr_pkg::phase_t phase, phase_next;
  logic              read_kind;
  logic [21:0]       wait_count;
  logic [5:0]        bit_index;
  logic [1:0]        frames_read;
  logic              ack_out, ack_next;
  logic [7:0]        frame_bytes [irtfr_pkg::FRAME_BYTES];

  logic        accept, is_start, is_sample;
  logic [21:0] wc_inc;
  logic        tmo_hit, low_done, high_done, tick;
  logic        shift_en, bit_step, frame_end, finish, done;
  logic [1:0]  frames_inc;
  logic [7:0]  id_sel;
  logic        id_hit;
  logic [2:0]  byte_idx;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;
  assign is_start    = accept && (items.opcode == irtfr_pkg::OP_START);
  assign is_sample   = accept && (items.opcode == irtfr_pkg::OP_SAMPLE);

  // Shared timeout: one tick for each sample that does not end its wait
  assign wc_inc    = wait_count + 22'd1;
  assign tmo_hit   = (wc_inc == cfg.timeout_ticks);
  assign low_done  = !items.clock_level || tmo_hit;
  assign high_done = items.clock_level || tmo_hit;
  assign tick      = is_sample &&
                     (((phase == irtfr_pkg::PH_LOW) && items.clock_level) ||
                      ((phase == irtfr_pkg::PH_HIGH) && !items.clock_level));

  assign shift_en   = is_sample && (phase == irtfr_pkg::PH_LOW) && low_done;
  assign bit_step   = is_sample && (phase == irtfr_pkg::PH_HIGH) && high_done;
  assign frame_end  = (bit_index == 6'(irtfr_pkg::FRAME_BITS - 1));
  assign frames_inc = frames_read + 2'd1;
  assign id_sel     = (read_kind == irtfr_pkg::KIND_AMBIENT) ? cfg.ambient_id : cfg.target_id;
  assign id_hit     = (frame_bytes[0] == id_sel);
  assign finish     = id_hit || (frames_inc == cfg.max_frames);
  assign done       = bit_step && frame_end && finish;
  assign byte_idx   = bit_index[5:3];

  // Next bit-timing state
  always_comb begin
    phase_next = phase;
    if (is_start) begin
      phase_next = irtfr_pkg::PH_LOW;
    end else if (is_sample) begin
      case (phase)
        irtfr_pkg::PH_IDLE: phase_next = irtfr_pkg::PH_IDLE;
        irtfr_pkg::PH_LOW:  if (low_done) phase_next = irtfr_pkg::PH_HIGH;
        irtfr_pkg::PH_HIGH: begin
          if (high_done) begin
            phase_next = (frame_end && finish) ? irtfr_pkg::PH_IDLE : irtfr_pkg::PH_LOW;
          end
        end
        default: phase_next = irtfr_pkg::PH_IDLE;
      endcase
    end
  end

  // Build the result stub for the back end
  always_comb begin
    ack_next = ack_out;
    if (is_start) begin
      ack_next = 1'b0;
    end else if (done) begin
      ack_next = 1'b1;
    end
    q_push             = accept;
    q_data.flags.ack   = ack_next;
    q_data.flags.busy  = (phase_next != irtfr_pkg::PH_IDLE);
    q_data.flags.done  = done;
    q_data.flags.valid = done && id_hit && (frame_bytes[4] == cfg.end_mark);
    q_data.flags.kind  = done ? read_kind : irtfr_pkg::KIND_TARGET;
    q_data.live        = q_data.flags.valid;
    q_data.raw         = {frame_bytes[1], frame_bytes[2]};
    q_data.offset      = (read_kind == irtfr_pkg::KIND_AMBIENT) ? cfg.ambient_offset
                                                               : cfg.target_offset;
  end

  // Advance read control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= irtfr_pkg::PH_IDLE;
      read_kind   <= irtfr_pkg::KIND_TARGET;
      wait_count  <= '0;
      bit_index   <= '0;
      frames_read <= '0;
      ack_out     <= 1'b1;
    end else begin
      phase   <= phase_next;
      ack_out <= ack_next;
      if (is_start) begin
        read_kind   <= items.kind;
        wait_count  <= '0;
        bit_index   <= '0;
        frames_read <= '0;
      end else begin
        if (tick) begin
          wait_count <= tmo_hit ? '0 : wc_inc;
        end
        if (bit_step) begin
          if (frame_end) begin
            bit_index   <= '0;
            frames_read <= frames_inc;
          end else begin
            bit_index <= bit_index + 6'd1;
          end
        end
      end
    end
  end

  // Shift data MSB first into the current frame byte
  always_ff @(posedge clk) begin
    if (shift_en) begin
      frame_bytes[byte_idx] <= {frame_bytes[byte_idx][6:0], items.data_level};
    end
  end

endmodule

// File: rtl/core/irtfr_fifo.sv
// Short queue of result stubs between the front and back ends.
`timescale 1ns / 1ps

module irtfr_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  irtfr_pkg::stub_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output irtfr_pkg::stub_t head
);

  irtfr_pkg::stub_t              mem [irtfr_pkg::FIFO_DEPTH];
  logic [irtfr_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [irtfr_pkg::FIFO_AW:0]   count;

  assign full  = (count == (irtfr_pkg::FIFO_AW + 1)'(irtfr_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  function automatic logic [irtfr_pkg::FIFO_AW-1:0] ptr_inc(
    input logic [irtfr_pkg::FIFO_AW-1:0] p
  );
    return (p == irtfr_pkg::FIFO_AW'(irtfr_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming stub
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/irtfr_back.sv
// Back end: converts raw readings to hundredths and ASCII digits.
`timescale 1ns / 1ps

module irtfr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  irtfr_pkg::stub_t q_data,
  output logic             q_pop,
  irtfr_result_if.source   results
);

  localparam int LAST = irtfr_pkg::BACK_STAGES - 1;

  logic [irtfr_pkg::BACK_STAGES-1:0] vld;
  irtfr_pkg::flags_t                 fl [irtfr_pkg::BACK_STAGES];
  logic                              adv;

  // stage 0
  logic [20:0]        raw25;
  logic signed [22:0] xs;
  logic [22:0]        xmag;
  logic [16:0]        m0;
  logic               neg0, live0;
  logic signed [10:0] off0;
  // stage 1
  logic [34:0]        prod1;
  logic [11:0]        degm1;
  logic               neg1, live1;
  logic signed [10:0] off1;
  // stage 2
  logic signed [19:0] degs, temp_c;
  logic signed [19:0] temp2;
  // stage 3
  logic signed [19:0] tabs;
  logic signed [19:0] temp3;
  logic               neg3;
  logic [18:0]        mag3;
  // stages 4 to 7
  logic signed [19:0] temp4, temp5, temp6, temp7;
  logic               neg4, neg5, neg6, neg7;
  logic [18:0]        q4, q5, q6;
  logic [3:0]         u4, u5, u6, u7;
  logic [3:0]         t5, t6, t7;
  logic [3:0]         h6, h7;
  logic [3:0]         th7;

  function automatic logic [18:0] div10(input logic [18:0] x);
    logic [37:0] prod;
    prod = 38'(x) * 38'(irtfr_pkg::RECIP_10);
    return {3'b0, prod[37:irtfr_pkg::RECIP_SHIFT]};
  endfunction

  function automatic logic [3:0] rem10(input logic [18:0] x, input logic [18:0] q);
    logic [18:0] r;
    r = x - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction

  // Stall the whole pipe while the output word waits
  assign adv   = !vld[LAST] || results.ready;
  assign q_pop = adv && !q_empty;

  // Stage 0 math: magnitude of raw*25 - bias, divided by 16
  assign raw25 = 21'({q_data.raw, 4'b0}) + 21'({q_data.raw, 3'b0}) + 21'(q_data.raw);
  assign xs    = $signed({2'b00, raw25}) - irtfr_pkg::RAW_BIAS;
  assign xmag  = xs[22] ? 23'(-xs) : 23'(xs);

  // Stage 1 math: divide by 25 through the reciprocal
  assign prod1 = 35'(m0) * 35'(irtfr_pkg::RECIP_25);

  // Stage 2 math: signed degrees times 100 plus offset
  assign degs   = neg1 ? -$signed({8'b0, degm1}) : $signed({8'b0, degm1});
  assign temp_c = degs * irtfr_pkg::DEG_SCALE + 20'(off1);

  // Stage 3 math: absolute value
  assign tabs = temp2[19] ? -temp2 : temp2;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], q_pop};
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      fl[0] <= q_data.flags;
      for (int i = 1; i < irtfr_pkg::BACK_STAGES; i++) begin
        fl[i] <= fl[i-1];
      end
      m0    <= xmag[20:4];
      neg0  <= xs[22];
      live0 <= q_data.live;
      off0  <= q_data.offset;

      degm1 <= prod1[irtfr_pkg::RECIP_SHIFT +: 12];
      neg1  <= neg0;
      live1 <= live0;
      off1  <= off0;

      temp2 <= live1 ? temp_c : '0;

      temp3 <= temp2;
      neg3  <= temp2[19];
      mag3  <= tabs[18:0];

      temp4 <= temp3;
      neg4  <= neg3;
      q4    <= div10(mag3);
      u4    <= rem10(mag3, div10(mag3));

      temp5 <= temp4;
      neg5  <= neg4;
      q5    <= div10(q4);
      u5    <= u4;
      t5    <= rem10(q4, div10(q4));

      temp6 <= temp5;
      neg6  <= neg5;
      q6    <= div10(q5);
      u6    <= u5;
      t6    <= t5;
      h6    <= rem10(q5, div10(q5));

      temp7 <= temp6;
      neg7  <= neg6;
      u7    <= u6;
      t7    <= t6;
      h7    <= h6;
      th7   <= rem10(q6, div10(q6));
    end
  end

  // Drive the result word from the last stage
  assign results.valid            = vld[LAST];
  assign results.ack_level        = fl[LAST].ack;
  assign results.busy_res         = fl[LAST].busy;
  assign results.done_res         = fl[LAST].done;
  assign results.valid_res        = fl[LAST].valid;
  assign results.reading_kind     = fl[LAST].kind;
  assign results.temperature_x100 = temp7;
  assign results.negative         = neg7;
  assign results.digit_thousands  = irtfr_pkg::ASCII_ZERO + {2'b0, th7};
  assign results.digit_hundreds   = irtfr_pkg::ASCII_ZERO + {2'b0, h7};
  assign results.digit_tens       = irtfr_pkg::ASCII_ZERO + {2'b0, t7};
  assign results.digit_units      = irtfr_pkg::ASCII_ZERO + {2'b0, u7};

endmodule

// File: rtl/core/ir_thermometer_frame_receiver.sv
// IR thermometer frame receiver: top level.
//
// Usage: the items channel carries one word per sensor pin sample, or a
// start word that opens a target or ambient read and drops acknowledge.
// Bits are taken on falling sensor clock edges into a 5-byte frame; a
// read ends on an identifier match or after max_frames frames, then
// acknowledge rises and the word carries done, valid, the reading in
// hundredths of a degree and its four ASCII digits with a sign flag.
// Every accepted word yields exactly one word on the results channel.
// Throughput: one word per cycle while the queue between front and back
// end has room. Path: an accepted word passes that queue, then the
// eight-stage conversion pipeline (divide by 400, scaling, then one
// divide-by-ten step per digit).
// Stall: while a result waits, the pipeline holds and a four-entry queue
// keeps taking words; items.ready drops only when that queue is full.
// Reset: synchronous, active high; clears control state, no clearing pass,
// registers return to their defaults. Configuration is on an APB-style
// port, register i at byte address 4*i.
`timescale 1ns / 1ps

module ir_thermometer_frame_receiver (
  input  logic                         clk,
  input  logic                         rst,
  irtfr_item_if.sink                   items,
  irtfr_result_if.source               results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irtfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  irtfr_pkg::cfg_t  cfg;
  irtfr_pkg::stub_t push_data, head;
  logic             push, pop, full, empty;

  irtfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irtfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .items  (items),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  irtfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  irtfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_data  (head),
    .q_pop   (pop),
    .results (results)
  );

endmodule

// File: rtl/core/irtfr_checker.sv
// Port-level checker of the frame receiver and its bind.
`timescale 1ns / 1ps
`include "ir_thermometer_frame_receiver_macros.svh"

module irtfr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               ack_level,
  input logic               busy_res,
  input logic               done_res,
  input logic               valid_res,
  input logic signed [19:0] temperature_x100,
  input logic               negative,
  input logic [5:0]         digit_thousands,
  input logic [5:0]         digit_units
);

  // A waiting result word holds
  `IRTFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(temperature_x100) && $stable(done_res) && $stable(digit_units))

  // A finished read raises acknowledge and is no longer busy
  `IRTFR_ASSERT_IMPL(a_done_ack, clk, rst, out_valid && done_res, ack_level && !busy_res)

  // A valid reading only comes with done
  `IRTFR_ASSERT_IMPL(a_valid_done, clk, rst, out_valid && valid_res, done_res)

  // Without a valid reading the value and digits stay at zero
  `IRTFR_ASSERT_IMPL(a_zero_fill, clk, rst, out_valid && !valid_res, (temperature_x100 == 20'sd0) && !negative && (digit_units == irtfr_pkg::ASCII_ZERO) && (digit_thousands == irtfr_pkg::ASCII_ZERO))

endmodule

bind ir_thermometer_frame_receiver irtfr_checker u_irtfr_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .ack_level        (results.ack_level),
  .busy_res         (results.busy_res),
  .done_res         (results.done_res),
  .valid_res        (results.valid_res),
  .temperature_x100 (results.temperature_x100),
  .negative         (results.negative),
  .digit_thousands  (results.digit_thousands),
  .digit_units      (results.digit_units)
);

// File: verif/tb_ir_thermometer_frame_receiver.sv
// Self-checking testbench for the IR thermometer frame receiver.
`timescale 1ns / 1ps

module tb_ir_thermometer_frame_receiver;

  localparam int ITEM_TARGET    = 1850;
  localparam int NUM_PHASES     = 6;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  // Kelvin offset scaled by 400: 273.15 * 400
  localparam int KELVIN_X400    = 109260;

  // One result word as the block reports it
  typedef struct packed {
    logic               ack;
    logic               busy;
    logic               done;
    logic               valid;
    logic               knd;
    logic signed [19:0] temp_x100;
    logic               neg;
    logic [5:0]         d_thou;
    logic [5:0]         d_hund;
    logic [5:0]         d_tens;
    logic [5:0]         d_units;
  } reading_t;

  // Directed word with its expected acknowledge and busy levels
  typedef struct packed {
    logic op;
    logic knd;
    logic ck;
    logic dt;
    logic ack;
    logic busy;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [irtfr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  irtfr_item_if   item_ch ();
  irtfr_result_if result_ch ();

  ir_thermometer_frame_receiver u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Shadow registers and receiver state, tracking the block word by word
  irtfr_pkg::cfg_t sensor_cfg = '{irtfr_pkg::RST_TARGET_ID, irtfr_pkg::RST_AMBIENT_ID,
                                  irtfr_pkg::RST_END_MARK, irtfr_pkg::RST_TIMEOUT_TICKS,
                                  irtfr_pkg::RST_MAX_FRAMES, irtfr_pkg::RST_TARGET_OFFSET,
                                  irtfr_pkg::RST_AMBIENT_OFFSET};
  logic        rd_active = 1'b0;
  logic        rd_kind   = 1'b0;
  logic        rd_phase  = 1'b0;
  logic [5:0]  rd_bit    = '0;
  logic [7:0]  frame_q [irtfr_pkg::FRAME_BYTES] = '{default: 8'h00};
  logic [1:0]  rd_frames = '0;
  logic [21:0] rd_wait   = '0;
  logic        ack_q     = 1'b1;

  reading_t pending_readings [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  gap_pct    = 0;
  int  stall_pct  = 0;
  int  stall_left = 0;
  int  stall_clock = 0;
  int  stalled_cycles = 0;
  int  corner_next = 0;
  bit  steady_tail = 1'b0;
  logic word_typed = 1'b0;
  logic typed_ack  = 1'b0;
  logic typed_busy = 1'b0;

  // Short directed opening: idle samples, starts, restarts mid-read
  row_t directed_rows [16] = '{
    // idle samples are ignored
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b0, 1'b0, 1'b1, 1'b0},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b1, 1'b1, 1'b0},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b0, 1'b1, 1'b1, 1'b0},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b0, 1'b1, 1'b0},
    // drop ack, go busy
    '{irtfr_pkg::OP_START,  irtfr_pkg::KIND_TARGET,  1'b1, 1'b1, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b1, 1'b0, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b0, 1'b1, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b0, 1'b0, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b1, 1'b0, 1'b1},
    // restart abandons the read
    '{irtfr_pkg::OP_START,  irtfr_pkg::KIND_AMBIENT, 1'b0, 1'b0, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b0, 1'b1, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b0, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_TARGET,  1'b0, 1'b0, 1'b0, 1'b1},
    '{irtfr_pkg::OP_SAMPLE, irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b1, 1'b0, 1'b1},
    '{irtfr_pkg::OP_START,  irtfr_pkg::KIND_TARGET,  1'b0, 1'b1, 1'b0, 1'b1},
    '{irtfr_pkg::OP_START,  irtfr_pkg::KIND_AMBIENT, 1'b1, 1'b0, 1'b0, 1'b1}
  };

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic pct(int p);
    return $urandom_range(0, 99) < p;
  endfunction

  function automatic int extra_samples();
    return pct(75) ? 0 : $urandom_range(1, 3);
  endfunction

  // Result of a word that finished no valid read
  function automatic reading_t blank_reading(logic ack, logic busy);
    reading_t r;
    r = '0;
    r.ack     = ack;
    r.busy    = busy;
    r.d_thou  = irtfr_pkg::ASCII_ZERO;
    r.d_hund  = irtfr_pkg::ASCII_ZERO;
    r.d_tens  = irtfr_pkg::ASCII_ZERO;
    r.d_units = irtfr_pkg::ASCII_ZERO;
    return r;
  endfunction

  function automatic string show(reading_t r);
    return $sformatf({"ack=%0b busy=%0b done=%0b valid=%0b kind=%0b temp=%0d neg=%0b",
                      " dig=%0d/%0d/%0d/%0d"},
                     r.ack, r.busy, r.done, r.valid, r.knd, r.temp_x100, r.neg,
                     r.d_thou, r.d_hund, r.d_tens, r.d_units);
  endfunction

  // Advance the shared wait counter; report a timeout
  function automatic logic wait_expired();
    rd_wait = rd_wait + 22'd1;
    if (rd_wait == sensor_cfg.timeout_ticks) begin
      rd_wait = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted word to the receiver state and return its reading
  function automatic reading_t next_reading(logic op, logic knd, logic ck, logic dt);
    reading_t r;
    logic hit;
    logic done;
    logic ok;
    logic [7:0] id;
    logic signed [10:0] off11;
    int raw;
    int deg;
    int temp;
    int unsigned mag;
    int idx;
    done = 1'b0;
    ok = 1'b0;
    if (op == irtfr_pkg::OP_START) begin
      ack_q = 1'b0;
      rd_active = 1'b1;
      rd_kind = knd;
      rd_phase = 1'b0;
      rd_bit = '0;
      rd_frames = '0;
      rd_wait = '0;
    end else if (rd_active) begin
      if (!rd_phase) begin
        // waiting for the clock to fall: take the data bit
        if (ck == 1'b0) hit = 1'b1;
        else hit = wait_expired();
        if (hit) begin
          idx = rd_bit >> 3;
          frame_q[idx] = {frame_q[idx][6:0], dt};
          rd_phase = 1'b1;
        end
      end else begin
        // waiting for the clock to rise: close the bit
        if (ck == 1'b1) hit = 1'b1;
        else hit = wait_expired();
        if (hit) begin
          rd_phase = 1'b0;
          rd_bit = rd_bit + 6'd1;
          if (rd_bit >= irtfr_pkg::FRAME_BITS) begin
            id = rd_kind ? sensor_cfg.ambient_id : sensor_cfg.target_id;
            rd_bit = '0;
            rd_frames = rd_frames + 2'd1;
            if (frame_q[0] == id || rd_frames == sensor_cfg.max_frames) begin
              rd_active = 1'b0;
              ack_q = 1'b1;
              done = 1'b1;
              ok = (frame_q[0] == id) && (frame_q[4] == sensor_cfg.end_mark);
            end
          end
        end
      end
    end
    r = blank_reading(ack_q, rd_active);
    r.done = done;
    r.valid = ok;
    if (done) r.knd = rd_kind;
    if (done && ok) begin
      raw = {frame_q[1], frame_q[2]};
      deg = (raw * 25 - KELVIN_X400) / 400;
      off11 = rd_kind ? sensor_cfg.ambient_offset : sensor_cfg.target_offset;
      temp = deg * 100 + off11;
      r.temp_x100 = 20'(temp);
      r.neg = temp < 0;
      mag = (temp < 0) ? -temp : temp;
      r.d_thou  = irtfr_pkg::ASCII_ZERO + 6'((mag / 1000) % 10);
      r.d_hund  = irtfr_pkg::ASCII_ZERO + 6'((mag / 100) % 10);
      r.d_tens  = irtfr_pkg::ASCII_ZERO + 6'((mag / 10) % 10);
      r.d_units = irtfr_pkg::ASCII_ZERO + 6'(mag % 10);
    end
    return r;
  endfunction

  // Raw readings at the conversion corners first, random later
  function automatic logic [15:0] pick_raw();
    logic [15:0] corners [8];
    corners = '{16'h0000, 16'hFFFF, 16'd4354, 16'd4355, 16'd4370, 16'd4386, 16'd4387,
                16'h8000};
    if (corner_next < 8) begin
      corner_next++;
      return corners[corner_next - 1];
    end
    return pct(20) ? corners[$urandom_range(0, 7)] : 16'($urandom);
  endfunction

  // Check result words, then record the expectation of the word taken
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    string diffs;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.ack       = result_ch.ack_level;
        got.busy      = result_ch.busy_res;
        got.done      = result_ch.done_res;
        got.valid     = result_ch.valid_res;
        got.knd       = result_ch.reading_kind;
        got.temp_x100 = result_ch.temperature_x100;
        got.neg       = result_ch.negative;
        got.d_thou    = result_ch.digit_thousands;
        got.d_hund    = result_ch.digit_hundreds;
        got.d_tens    = result_ch.digit_tens;
        got.d_units   = result_ch.digit_units;
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no reading expected: %s", $realtime, show(got));
        end else begin
          want = pending_readings.pop_front();
          diffs = "";
          if (want.ack !== got.ack) diffs = {diffs, " ack_level"};
          if (want.busy !== got.busy) diffs = {diffs, " busy_res"};
          if (want.done !== got.done) diffs = {diffs, " done_res"};
          if (want.valid !== got.valid) diffs = {diffs, " valid_res"};
          if (want.knd !== got.knd) diffs = {diffs, " reading_kind"};
          if (want.temp_x100 !== got.temp_x100) diffs = {diffs, " temperature_x100"};
          if (want.neg !== got.neg) diffs = {diffs, " negative"};
          if (want.d_thou !== got.d_thou) diffs = {diffs, " digit_thousands"};
          if (want.d_hund !== got.d_hund) diffs = {diffs, " digit_hundreds"};
          if (want.d_tens !== got.d_tens) diffs = {diffs, " digit_tens"};
          if (want.d_units !== got.d_units) diffs = {diffs, " digit_units"};
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: reading mismatch in%s\n  expected %s\n  actual   %s",
                       $realtime, diffs, show(want), show(got));
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        want = next_reading(item_ch.opcode, item_ch.kind, item_ch.clock_level,
                            item_ch.data_level);
        if (word_typed) want = blank_reading(typed_ack, typed_busy);
        pending_readings.push_back(want);
      end
    end
  end

  // Result-side stalls in bursts, at a randomly chosen rate of 0, 4 or 20 percent
  always @(negedge clk) begin
    stall_clock++;
    if (stall_clock % 128 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 4;
        default: stall_pct = 20;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 8);
    end
    result_ch.ready <= (stall_left == 0);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("tb_ir_thermometer_frame_receiver failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Drive one word, with an occasional gap before it; hold until taken
  task automatic send_word(logic op, logic knd, logic ck, logic dt,
                           logic typed = 1'b0, logic t_ack = 1'b0, logic t_busy = 1'b0);
    @(negedge clk);
    if (!steady_tail && gap_pct != 0 && pct(gap_pct)) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.opcode      <= op;
    item_ch.kind        <= knd;
    item_ch.clock_level <= ck;
    item_ch.data_level  <= dt;
    word_typed = typed;
    typed_ack  = t_ack;
    typed_busy = t_busy;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Hold the sender until every expected reading has arrived, then settle
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(irtfr_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      irtfr_pkg::REG_TARGET_ID:      sensor_cfg.target_id      = value[7:0];
      irtfr_pkg::REG_AMBIENT_ID:     sensor_cfg.ambient_id     = value[7:0];
      irtfr_pkg::REG_END_MARK:       sensor_cfg.end_mark       = value[7:0];
      irtfr_pkg::REG_TIMEOUT_TICKS:  sensor_cfg.timeout_ticks  = value[21:0];
      irtfr_pkg::REG_MAX_FRAMES:     sensor_cfg.max_frames     = value[1:0];
      irtfr_pkg::REG_TARGET_OFFSET:  sensor_cfg.target_offset  = value[10:0];
      irtfr_pkg::REG_AMBIENT_OFFSET: sensor_cfg.ambient_offset = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(irtfr_pkg::cfg_t c);
    drain();
    write_reg(irtfr_pkg::REG_TARGET_ID,      {24'd0, c.target_id});
    write_reg(irtfr_pkg::REG_AMBIENT_ID,     {24'd0, c.ambient_id});
    write_reg(irtfr_pkg::REG_END_MARK,       {24'd0, c.end_mark});
    write_reg(irtfr_pkg::REG_TIMEOUT_TICKS,  {10'd0, c.timeout_ticks});
    write_reg(irtfr_pkg::REG_MAX_FRAMES,     {30'd0, c.max_frames});
    write_reg(irtfr_pkg::REG_TARGET_OFFSET,  {21'd0, c.target_offset});
    write_reg(irtfr_pkg::REG_AMBIENT_OFFSET, {21'd0, c.ambient_offset});
  endtask

  // Start a read and clock out frames, MSB of byte 0 first
  task automatic send_read(logic knd);
    logic [7:0]  id;
    logic [7:0]  b0;
    logic [7:0]  b4;
    logic [15:0] raw;
    logic [39:0] frame;
    int nf;
    int cut;
    id = knd ? sensor_cfg.ambient_id : sensor_cfg.target_id;
    nf = (sensor_cfg.max_frames == 2'd0) ? 4 : int'(sensor_cfg.max_frames);
    case ($urandom_range(0, 3))
      0, 1: gap_pct = 0;
      2: gap_pct = 5;
      default: gap_pct = 20;
    endcase
    send_word(irtfr_pkg::OP_START, knd, coin(), coin());
    for (int f = 0; f < nf; f++) begin
      b0 = pct((f == nf - 1) ? 85 : 35) ? id : 8'($urandom);
      b4 = pct(85) ? sensor_cfg.end_mark : 8'($urandom);
      raw = (b0 == id) ? pick_raw() : 16'($urandom);
      frame = {b0, raw, 8'($urandom), b4};
      // now and then break the frame off early
      cut = pct(4) ? $urandom_range(0, irtfr_pkg::FRAME_BITS - 1) : irtfr_pkg::FRAME_BITS;
      for (int b = 0; b < cut; b++) begin
        repeat (extra_samples()) send_word(irtfr_pkg::OP_SAMPLE, coin(), 1'b1, coin());
        send_word(irtfr_pkg::OP_SAMPLE, coin(), 1'b0, frame[irtfr_pkg::FRAME_BITS - 1 - b]);
        repeat (extra_samples()) send_word(irtfr_pkg::OP_SAMPLE, coin(), 1'b0, coin());
        send_word(irtfr_pkg::OP_SAMPLE, coin(), 1'b1, coin());
      end
      if (cut < irtfr_pkg::FRAME_BITS || b0 == id) break;
    end
  endtask

  initial begin
    irtfr_pkg::cfg_t next_cfg;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.opcode = irtfr_pkg::OP_START;
    item_ch.kind = irtfr_pkg::KIND_TARGET;
    item_ch.clock_level = 1'b0;
    item_ch.data_level = 1'b0;
    result_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words, checked against the typed levels
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].knd, directed_rows[i].ck,
                directed_rows[i].dt, 1'b1, directed_rows[i].ack, directed_rows[i].busy);

    // Random reads over several register settings, extremes first
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: next_cfg = '{8'h00, 8'hFF, 8'h00, 22'd1, 2'd1, 11'h400, 11'h3FF};
          2: next_cfg = '{8'hFF, 8'h00, 8'hFF, 22'h3FFFFF, 2'd0, 11'sd1000, -11'sd1000};
          3: next_cfg = '{8'($urandom), 8'($urandom), 8'($urandom), 22'd0, 2'd2,
                          11'sd0, 11'sd0};
          default: begin
            next_cfg.target_id      = 8'($urandom);
            next_cfg.ambient_id     = 8'($urandom);
            next_cfg.end_mark       = 8'($urandom);
            next_cfg.timeout_ticks  = pct(40) ? 22'($urandom_range(1, 6))
                                              : 22'($urandom_range(7, 22'h3FFFFF));
            next_cfg.max_frames     = 2'($urandom);
            next_cfg.target_offset  = 11'($urandom);
            next_cfg.ambient_offset = 11'($urandom);
          end
        endcase
        apply_settings(next_cfg);
      end
      steady_tail = (p == NUM_PHASES - 1);
      while (items_sent < (p + 1) * ITEM_TARGET / NUM_PHASES) begin
        if (pct(15)) begin
          // stray words, mostly samples while idle
          gap_pct = 10;
          repeat ($urandom_range(1, 4))
            send_word(pct(12) ? irtfr_pkg::OP_START : irtfr_pkg::OP_SAMPLE,
                      coin(), coin(), coin());
        end else begin
          send_read(coin());
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_ir_thermometer_frame_receiver passed");
    end else begin
      $display("tb_ir_thermometer_frame_receiver failed");
    end
    $finish;
  end

endmodule

// File: ir_thermometer_frame_receiver.f
+incdir+rtl/core
rtl/core/irtfr_pkg.sv
rtl/core/irtfr_if.sv
rtl/core/irtfr_regs.sv
rtl/core/irtfr_front.sv
rtl/core/irtfr_fifo.sv
rtl/core/irtfr_back.sv
rtl/core/ir_thermometer_frame_receiver.sv
rtl/core/irtfr_checker.sv
verif/tb_ir_thermometer_frame_receiver.sv
